// ----- sv/mrf_pkg.sv -----
// Shared types, constants and the CRC-16/Modbus byte step for the Modbus RTU request framer.
// No dependencies; imported by every module of the framer.
`default_nettype none

package mrf_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // Position of each byte in the frame, including the first CRC byte and the last byte
    localparam logic [IDX_W-1:0] IDX_FIRST   = '0;
    localparam logic [IDX_W-1:0] IDX_FN      = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_REG_HI  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_REG_LO  = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_VAL_HI  = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_VAL_LO  = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_CRC_A   = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_BYTES - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
    localparam logic [7:0] FN_READ_HOLDING = 8'd3;

    // Request modes as carried on the input tuser bit
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Two-entry queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // First six frame bytes of one request, already classified
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] register_address;
        logic [15:0] value;
    } hdr_t;

    // Handshake group for a header moving front to queue or queue to back
    typedef struct packed {
        logic valid;
        hdr_t data;
    } hdr_xfer_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mrf_front.sv -----
// Front end of the Modbus RTU request framer: accepts requests and builds the frame header.
// Depends on mrf_pkg.
`default_nettype none

module mrf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [mrf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tuser,
    output mrf_pkg::hdr_xfer_t                 push,
    input  wire logic                          push_ready
);
    import mrf_pkg::*;

    logic hdr_valid_reg;
    logic hdr_valid_next;
    hdr_t hdr_reg;
    hdr_t hdr_next;
    logic accept;

    assign s_axis_tready = !hdr_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Pick the function code and drop the value for reads
    always_comb
    begin
        hdr_next.slave_address    = s_axis_tdata[7:0];
        hdr_next.register_address = s_axis_tdata[23:8];
        unique case (s_axis_tuser)
            MODE_READ:
            begin
                hdr_next.function_code = FN_READ_HOLDING;
                hdr_next.value         = '0;
            end
            default:
            begin
                hdr_next.function_code = FN_WRITE_SINGLE;
                hdr_next.value         = s_axis_tdata[39:24];
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            hdr_valid_next = 1'b1;
        else if (push_ready)
            hdr_valid_next = 1'b0;
        else
            hdr_valid_next = hdr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hdr_valid_reg <= 1'b0;
        else
            hdr_valid_reg <= hdr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hdr_reg <= hdr_next;
    end

    assign push.valid = hdr_valid_reg;
    assign push.data  = hdr_reg;

endmodule

`default_nettype wire

// ----- sv/mrf_queue.sv -----
// Two-entry header queue between the front and back ends of the framer.
// Depends on mrf_pkg.
`default_nettype none

module mrf_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mrf_pkg::hdr_xfer_t push,
    output logic                   push_ready,
    output mrf_pkg::hdr_xfer_t     pop,
    input  wire logic              pop_ready
);
    import mrf_pkg::*;

    hdr_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    assign pop.valid = (count_reg != '0);
    assign pop.data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.data;
    end

endmodule

`default_nettype wire

// ----- sv/mrf_back.sv -----
// Back end of the framer: serializes one header into eight bytes and folds in the CRC.
// Depends on mrf_pkg.
`default_nettype none

module mrf_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      crc_low_first,
    input  wire mrf_pkg::hdr_xfer_t        pop,
    output logic                           pop_ready,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     out_byte,
    output logic [mrf_pkg::IDX_W-1:0]      out_index,
    output logic                           out_last
);
    import mrf_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [15:0]      crc_seed;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_last_reg;
    logic [7:0]       byte_sel;
    logic             load;

    assign load      = pop.valid && (!out_valid_reg || out_ready);
    assign pop_ready = load && (idx_reg == IDX_LAST);
    assign crc_seed  = (idx_reg == IDX_FIRST) ? CRC_INIT : crc_reg;

    always_comb
    begin
        unique case (idx_reg)
            IDX_FIRST:  byte_sel = pop.data.slave_address;
            IDX_FN:     byte_sel = pop.data.function_code;
            IDX_REG_HI: byte_sel = pop.data.register_address[15:8];
            IDX_REG_LO: byte_sel = pop.data.register_address[7:0];
            IDX_VAL_HI: byte_sel = pop.data.value[15:8];
            IDX_VAL_LO: byte_sel = pop.data.value[7:0];
            IDX_CRC_A:  byte_sel = crc_low_first ? crc_reg[7:0] : crc_reg[15:8];
            default:    byte_sel = crc_low_first ? crc_reg[15:8] : crc_reg[7:0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = (idx_reg == IDX_LAST) ? IDX_FIRST : idx_reg + 1'b1;
            if (idx_reg < IDX_CRC_A)
                crc_next = crc_byte(crc_seed, byte_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (load)
        begin
            out_byte_reg  <= byte_sel;
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg == IDX_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/modbus_rtu_request_framer_top.sv -----
// A request passes the front header register, a queue entry and the back-end output register.
// Throughput: one frame byte per cycle while m_axis_tready is high, set by the back end's
// byte serializer, which folds each header byte into the CRC-16/Modbus.
// A new request is accepted while the previous frame is still being sent.
// Reset (rst_n, async, active low) empties the header stage, queue and output register
// and clears crc_low_first to 0 (CRC high byte first).
`default_nettype none

module modbus_rtu_request_framer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration: bit 0 is crc_low_first
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] slave_address, [23:8] register_address, [39:24] write_value
    input  wire logic [mrf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] mode: 0 write single register, 1 read holding register
    input  wire logic                          s_axis_tuser,
    // Frame byte stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] frame_byte, [10:8] byte_index, [15:11] zero
    output logic [mrf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // last_byte: final CRC byte of the frame
    output logic                               m_axis_tlast
);
    import mrf_pkg::*;

    logic             crc_low_first_reg;
    hdr_xfer_t        push;
    logic             push_ready;
    hdr_xfer_t        pop;
    logic             pop_ready;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_index;

    // Hold the CRC byte order; write only while no frame is in flight (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_low_first_reg <= 1'b0;
        else if (cfg_wr_en)
            crc_low_first_reg <= cfg_wr_data;
    end

    // Front end: accept a request transaction, pick the function code, zero the value on reads
    mrf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_ready    (push_ready)
    );

    // Queue: lets the front take the next request while the back is mid-frame
    mrf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    // Back end: send six header bytes while advancing the CRC, then the two CRC bytes
    mrf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .crc_low_first (crc_low_first_reg),
        .pop           (pop),
        .pop_ready     (pop_ready),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (out_byte),
        .out_index     (out_index),
        .out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {(M_TDATA_W - 8 - IDX_W)'(0), out_index, out_byte};

    // tlast marks exactly the last byte position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[10:8] == IDX_LAST)))
        else $error("tlast does not match last byte position");

    // Inside a frame the next byte follows at once with the next index
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tdata[10:8] == $past(m_axis_tdata[10:8]) + 3'd1)))
        else $error("frame bytes not contiguous");

    // Function code byte is one of the two supported codes
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[10:8] == IDX_FN)) |->
        ((m_axis_tdata[7:0] == FN_READ_HOLDING) || (m_axis_tdata[7:0] == FN_WRITE_SINGLE)))
        else $error("bad function code byte");

endmodule

`default_nettype wire
